[rtl/core/ldcp_pkg.sv]
// Shared types, codes and constants for the laser DAC command parser.
package ldcp_pkg;

   localparam int unsigned FRAME_CAPACITY_DEF = 1800;
   localparam int unsigned MAX_RESULTS        = 3;

   // Operation codes on the request channel
   localparam logic [1:0] OP_BYTE    = 2'd0;
   localparam logic [1:0] OP_CONNECT = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_STATUS  = 3'd0;
   localparam logic [2:0] KIND_POINT   = 3'd1;
   localparam logic [2:0] KIND_COMMIT  = 3'd2;
   localparam logic [2:0] KIND_DISCARD = 3'd3;
   localparam logic [2:0] KIND_DROP    = 3'd4;
   localparam logic [2:0] KIND_ESTOP   = 3'd5;

   localparam logic REPLY_ACK = 1'b0;
   localparam logic REPLY_BAD = 1'b1;

   // Command bytes
   localparam logic [7:0] OPC_PING    = 8'h3F;
   localparam logic [7:0] OPC_PREPARE = 8'h70;
   localparam logic [7:0] OPC_BEGIN   = 8'h62;
   localparam logic [7:0] OPC_DATA    = 8'h64;
   localparam logic [7:0] OPC_STOP    = 8'h73;
   localparam logic [7:0] OPC_ESTOP0  = 8'h00;
   localparam logic [7:0] OPC_ESTOP1  = 8'hFF;
   localparam logic [7:0] OPC_CLEAR   = 8'h63;
   localparam logic [7:0] OPC_NONE    = 8'h00;

   localparam logic [1:0] ENGINE_READY = 2'd0;
   localparam logic [1:0] ENGINE_ESTOP = 2'd3;

   localparam logic [1:0] PLAY_IDLE     = 2'd0;
   localparam logic [1:0] PLAY_PREPARED = 2'd1;
   localparam logic [1:0] PLAY_PLAYING  = 2'd2;

   // Byte positions inside the begin arguments, data header and a point
   localparam logic [4:0] ARGS_LAST_IDX  = 5'd7;
   localparam logic [4:0] HDR_CNT_LO_IDX = 5'd4;
   localparam logic [4:0] HDR_CNT_HI_IDX = 5'd5;
   localparam logic [4:0] PT_CTRL_IDX    = 5'd1;
   localparam logic [4:0] PT_X_LO_IDX    = 5'd2;
   localparam logic [4:0] PT_X_HI_IDX    = 5'd3;
   localparam logic [4:0] PT_Y_LO_IDX    = 5'd4;
   localparam logic [4:0] PT_Y_HI_IDX    = 5'd5;
   localparam logic [4:0] PT_COL_FIRST   = 5'd6;
   localparam logic [4:0] PT_COL_LAST    = 5'd11;
   localparam logic [4:0] PT_LAST_IDX    = 5'd17;

   localparam logic REG_OUTPUT_ENABLED = 1'b0;

   typedef enum logic [1:0] {
      PH_CMD,
      PH_ARGS,
      PH_HDR,
      PH_PTS
   } phase_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic               response_code;
      logic [7:0]         echoed_command;
      logic [1:0]         engine_state;
      logic [1:0]         play_state;
      logic [10:0]        fullness;
      logic [31:0]        total_points;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [23:0]        colour;
      logic               blank;
   } rec_type;

   // Results caused by one request beat
   typedef struct packed {
      logic [1:0]    count;
      rec_type [2:0] recs;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

[rtl/core/ldcp_chan_if.sv]
// Valid/ready channel interfaces for request and response beats.
interface ldcp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [7:0] data_byte;
   logic       safety_ok;

   modport source (output valid, output operation, output data_byte, output safety_ok,
                   input ready);
   modport sink   (input valid, input operation, input data_byte, input safety_ok,
                   output ready);
endinterface

interface ldcp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic               response_code;
   logic [7:0]         echoed_command;
   logic [1:0]         engine_state;
   logic [1:0]         play_state;
   logic [10:0]        fullness;
   logic [31:0]        total_points;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   logic [23:0]        colour;
   logic               blank;
   logic               last;

   modport source (output valid, output kind, output response_code, output echoed_command,
                   output engine_state, output play_state, output fullness,
                   output total_points, output point_x, output point_y, output colour,
                   output blank, output last, input ready);
   modport sink   (input valid, input kind, input response_code, input echoed_command,
                   input engine_state, input play_state, input fullness,
                   input total_points, input point_x, input point_y, input colour,
                   input blank, input last, output ready);
endinterface

[rtl/core/ldcp_front.sv]
// Front end: parses request beats, updates protocol state, builds result bundles.
module ldcp_front #(
   parameter int unsigned FRAME_CAPACITY = ldcp_pkg::FRAME_CAPACITY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  output_enabled,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_safety_ok,
   input  ldcp_pkg::queue_stat_type q_stat,
   output logic                  push,
   output ldcp_pkg::bundle_type  push_data
);
   import ldcp_pkg::*;

   localparam int unsigned CW = $clog2(FRAME_CAPACITY + 1);
   // Remainder of 2^32 by the capacity, taken off when the total wraps
   localparam logic [63:0] WRAP_REM = 64'h1_0000_0000 % 64'(FRAME_CAPACITY);

   phase_type      phase_ff, phase_in;
   logic [4:0]     idx_ff, idx_in;
   logic [15:0]    hdr_ff, hdr_in;
   logic [CW-1:0]  left_ff, left_in;
   logic [CW-1:0]  fcnt_ff, fcnt_in;
   logic           shut_ff, shut_in;
   logic [15:0]    x_ff, x_in, y_ff, y_in;
   logic [47:0]    colw_ff, colw_in;
   logic           run_ff, run_in, prep_ff, prep_in;
   logic [31:0]    total_ff, total_in;
   logic [CW-1:0]  full_ff, full_in;

   logic           accept;
   logic [1:0]     n;
   rec_type [2:0]  recs;
   logic [CW:0]    full_sum;
   logic [1:0]     play_new;

   function automatic rec_type mk(input logic [2:0] k, input logic c, input logic [7:0] cm);
      rec_type r;
      r = '0;
      r.kind = k;
      r.response_code = c;
      r.echoed_command = cm;
      return r;
   endfunction

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in = phase_ff;  idx_in = idx_ff;    hdr_in = hdr_ff;
      left_in  = left_ff;   fcnt_in = fcnt_ff;  shut_in = shut_ff;
      x_in     = x_ff;      y_in = y_ff;        colw_in = colw_ff;
      run_in   = run_ff;    prep_in = prep_ff;  total_in = total_ff;
      full_in  = full_ff;
      n        = 2'd0;
      recs     = '0;
      full_sum = '0;

      case (req_operation)
         OP_BYTE: begin
            unique case (phase_ff)
               PH_CMD: begin
                  case (req_data_byte)
                     OPC_PING, OPC_CLEAR: begin
                        recs[n] = mk(KIND_STATUS, REPLY_ACK, req_data_byte); n = n + 2'd1;
                     end
                     OPC_PREPARE: begin
                        prep_in = 1'b1; run_in = 1'b0; total_in = '0; full_in = '0;
                        recs[n] = mk(KIND_STATUS, REPLY_ACK, req_data_byte); n = n + 2'd1;
                     end
                     OPC_BEGIN: begin
                        phase_in = PH_ARGS; idx_in = '0;
                     end
                     OPC_DATA: begin
                        phase_in = PH_HDR; idx_in = '0; hdr_in = '0;
                     end
                     OPC_STOP: begin
                        run_in = 1'b0;
                        recs[n] = mk(KIND_STATUS, REPLY_ACK, req_data_byte); n = n + 2'd1;
                     end
                     OPC_ESTOP0, OPC_ESTOP1: begin
                        run_in = 1'b0;
                        recs[n] = mk(KIND_ESTOP, REPLY_ACK, OPC_NONE); n = n + 2'd1;
                        recs[n] = mk(KIND_STATUS, REPLY_ACK, req_data_byte); n = n + 2'd1;
                     end
                     default: ;
                  endcase
               end
               PH_ARGS: begin
                  if (idx_ff < ARGS_LAST_IDX) begin
                     idx_in = idx_ff + 5'd1;
                  end else begin
                     idx_in = '0; phase_in = PH_CMD; run_in = 1'b1;
                     recs[n] = mk(KIND_STATUS, REPLY_ACK, OPC_BEGIN); n = n + 2'd1;
                  end
               end
               PH_HDR: begin
                  if (idx_ff == HDR_CNT_LO_IDX) hdr_in[7:0] = req_data_byte;
                  if (idx_ff == HDR_CNT_HI_IDX) hdr_in[15:8] = req_data_byte;
                  if (idx_ff < HDR_CNT_HI_IDX) begin
                     idx_in = idx_ff + 5'd1;
                  end else begin
                     idx_in = '0; phase_in = PH_CMD;
                     if ({1'b0, hdr_in} > 17'(FRAME_CAPACITY)) begin
                        recs[n] = mk(KIND_STATUS, REPLY_BAD, OPC_DATA); n = n + 2'd1;
                        recs[n] = mk(KIND_DROP, REPLY_ACK, OPC_NONE); n = n + 2'd1;
                     end else if (hdr_in == '0) begin
                        // Empty frame: never commits since the count is zero
                        fcnt_in = '0;
                        recs[n] = mk(KIND_DISCARD, REPLY_ACK, OPC_NONE); n = n + 2'd1;
                        recs[n] = mk(KIND_STATUS, REPLY_ACK, OPC_DATA); n = n + 2'd1;
                     end else begin
                        phase_in = PH_PTS; left_in = hdr_in[CW-1:0]; fcnt_in = '0;
                     end
                  end
               end
               PH_PTS: begin
                  if (idx_ff == PT_CTRL_IDX) shut_in = req_data_byte[7];
                  if (idx_ff == PT_X_LO_IDX) x_in[7:0]  = req_data_byte;
                  if (idx_ff == PT_X_HI_IDX) x_in[15:8] = req_data_byte;
                  if (idx_ff == PT_Y_LO_IDX) y_in[7:0]  = req_data_byte;
                  if (idx_ff == PT_Y_HI_IDX) y_in[15:8] = req_data_byte;
                  if (idx_ff >= PT_COL_FIRST && idx_ff <= PT_COL_LAST)
                     colw_in[(idx_ff - PT_COL_FIRST) * 8 +: 8] = req_data_byte;
                  if (idx_ff < PT_LAST_IDX) begin
                     idx_in = idx_ff + 5'd1;
                  end else begin
                     idx_in = '0;
                     recs[n] = mk(KIND_POINT, REPLY_ACK, OPC_NONE);
                     recs[n].point_x = x_ff;
                     recs[n].point_y = y_ff;
                     recs[n].colour  = {colw_ff[15:8], colw_ff[31:24], colw_ff[47:40]};
                     recs[n].blank   = shut_ff || (colw_ff == '0);
                     n = n + 2'd1;
                     fcnt_in = fcnt_ff + 1'b1;
                     if (left_ff != '0) left_in = left_ff - 1'b1;
                     if (left_in == '0) begin
                        phase_in = PH_CMD;
                        if (run_ff && output_enabled) begin
                           total_in = total_ff + 32'(fcnt_in);
                           full_sum = {1'b0, full_ff} + {1'b0, fcnt_in};
                           // Total wrapped at 32 bits: the remainder loses 2^32 too
                           if (total_in < total_ff) begin
                              if (full_sum >= (CW+1)'(WRAP_REM))
                                 full_sum = full_sum - (CW+1)'(WRAP_REM);
                              else
                                 full_sum = full_sum + (CW+1)'(FRAME_CAPACITY)
                                            - (CW+1)'(WRAP_REM);
                           end
                           if (full_sum >= (CW+1)'(FRAME_CAPACITY))
                              full_sum = full_sum - (CW+1)'(FRAME_CAPACITY);
                           full_in = full_sum[CW-1:0];
                           recs[n] = mk(KIND_COMMIT, REPLY_ACK, OPC_NONE); n = n + 2'd1;
                        end else begin
                           recs[n] = mk(KIND_DISCARD, REPLY_ACK, OPC_NONE); n = n + 2'd1;
                        end
                        recs[n] = mk(KIND_STATUS, REPLY_ACK, OPC_DATA); n = n + 2'd1;
                     end
                  end
               end
            endcase
         end
         OP_CONNECT: begin
            phase_in = PH_CMD; idx_in = '0; run_in = 1'b0; prep_in = 1'b0;
            recs[n] = mk(KIND_STATUS, REPLY_ACK, OPC_NONE); n = n + 2'd1;
         end
         OP_TIMEOUT: begin
            phase_in = PH_CMD; idx_in = '0;
            if (phase_ff == PH_ARGS) begin
               run_in = 1'b1;
               recs[n] = mk(KIND_STATUS, REPLY_ACK, OPC_BEGIN); n = n + 2'd1;
            end else if (phase_ff == PH_PTS) begin
               recs[n] = mk(KIND_DISCARD, REPLY_ACK, OPC_NONE); n = n + 2'd1;
               recs[n] = mk(KIND_STATUS, REPLY_BAD, OPC_DATA); n = n + 2'd1;
            end
         end
         default: ;
      endcase

      // Status fields: a point shows the totals before its frame commits,
      // every other result shows the state after this beat
      play_new = run_in ? PLAY_PLAYING : (prep_in ? PLAY_PREPARED : PLAY_IDLE);
      for (int i = 0; i < 3; i++) begin
         recs[i].engine_state = req_safety_ok ? ENGINE_READY : ENGINE_ESTOP;
         recs[i].play_state   = play_new;
         if (recs[i].kind == KIND_POINT) begin
            recs[i].total_points = total_ff;
            recs[i].fullness     = 11'(full_ff);
         end else begin
            recs[i].total_points = total_in;
            recs[i].fullness     = 11'(full_in);
         end
      end
   end

   assign push            = accept && (n != 2'd0);
   assign push_data.count = n;
   assign push_data.recs  = recs;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CMD; idx_ff <= '0;  hdr_ff <= '0;  left_ff <= '0;
         fcnt_ff  <= '0;     shut_ff <= 1'b0; x_ff <= '0;  y_ff <= '0;
         colw_ff  <= '0;     run_ff <= 1'b0; prep_ff <= 1'b0;
         total_ff <= '0;     full_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in; idx_ff <= idx_in;   hdr_ff <= hdr_in;  left_ff <= left_in;
         fcnt_ff  <= fcnt_in;  shut_ff <= shut_in; x_ff <= x_in;      y_ff <= y_in;
         colw_ff  <= colw_in;  run_ff <= run_in;   prep_ff <= prep_in;
         total_ff <= total_in; full_ff <= full_in;
      end
   end

endmodule

[rtl/core/ldcp_queue.sv]
// Two-entry queue of result bundles between the parser and the output stage.
module ldcp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ldcp_pkg::bundle_type     push_data,
   input  logic                     pop,
   output ldcp_pkg::bundle_type     head,
   output ldcp_pkg::queue_stat_type stat
);
   import ldcp_pkg::*;

   bundle_type  ent_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  cnt_ff, cnt_in;

   assign head       = ent_ff[rd_ff];
   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= push_data;
   end

endmodule

[rtl/core/ldcp_back.sv]
// Back end: walks the results of the head bundle onto the response channel.
module ldcp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  ldcp_pkg::bundle_type     head,
   input  ldcp_pkg::queue_stat_type q_stat,
   output logic                     pop,
   ldcp_rsp_if.source               rsp
);
   import ldcp_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       is_last, beat;
   rec_type    cur;

   assign cur     = head.recs[idx_ff];
   assign is_last = (idx_ff == head.count - 2'd1);
   assign beat    = rsp.valid && rsp.ready;
   assign pop     = beat && is_last;
   assign idx_in  = pop ? 2'd0 : idx_ff + 2'd1;

   assign rsp.valid          = !q_stat.empty;
   assign rsp.kind           = cur.kind;
   assign rsp.response_code  = cur.response_code;
   assign rsp.echoed_command = cur.echoed_command;
   assign rsp.engine_state   = cur.engine_state;
   assign rsp.play_state     = cur.play_state;
   assign rsp.fullness       = cur.fullness;
   assign rsp.total_points   = cur.total_points;
   assign rsp.point_x        = cur.point_x;
   assign rsp.point_y        = cur.point_y;
   assign rsp.colour         = cur.colour;
   assign rsp.blank          = cur.blank;
   assign rsp.last           = is_last;

   // Result index within the head bundle
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (beat) begin
         idx_ff <= idx_in;
      end
   end

endmodule

[rtl/core/laser_dac_command_parser_top.sv]
// Laser DAC command parser: top level with the configuration register.
//
// Request channel (req_bus) carries one beat per stream event: a received
// byte, a client connect or a read timeout, with the safety status. Each
// beat yields zero to three response beats on rsp_bus (status replies,
// points, frame commit or discard, drop, estop request); last marks the
// final response of a request beat.
// A request beat is taken every cycle while the two-entry bundle queue has
// room; responses leave at one per cycle while the receiver is ready, so a
// beat with k results takes k response beats. A request beat's results are
// registered in the bundle queue before its first response is offered. The
// output stage reads the queue head, so a stalled receiver only backs up the
// queue; the parser keeps taking beats until two bundles wait.
// Reset clears the parser state, the queue and output_enabled; the block
// takes a beat in the first cycle after reset.
// CSR: output_enabled at byte address 0 via an APB-style port, pready tied
// high.
module laser_dac_command_parser_top #(
   parameter int unsigned FRAME_CAPACITY = ldcp_pkg::FRAME_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ldcp_req_if.sink    req_bus,
   ldcp_rsp_if.source  rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import ldcp_pkg::*;

   logic           enable_ff;
   logic           push, pop;
   bundle_type     push_data, head;
   queue_stat_type q_stat;
   logic           sel_enable;

   assign csr_pready = 1'b1;
   assign sel_enable = (csr_paddr[2] == REG_OUTPUT_ENABLED);
   assign csr_prdata = sel_enable ? {31'd0, enable_ff} : 32'd0;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && sel_enable) begin
         enable_ff <= csr_pwdata[0];
      end
   end

   ldcp_front #(.FRAME_CAPACITY(FRAME_CAPACITY)) u_front (
      .clock          (clock),
      .reset          (reset),
      .output_enabled (enable_ff),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_operation  (req_bus.operation),
      .req_data_byte  (req_bus.data_byte),
      .req_safety_ok  (req_bus.safety_ok),
      .q_stat         (q_stat),
      .push           (push),
      .push_data      (push_data)
   );

   ldcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .stat      (q_stat)
   );

   ldcp_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .rsp    (rsp_bus)
   );

endmodule

[rtl/core/ldcp_checker.sv]
// Port-level checks on the response channel, bound to the top level.
module ldcp_checker #(
   parameter int unsigned FRAME_CAPACITY = ldcp_pkg::FRAME_CAPACITY_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [10:0] rsp_fullness,
   input logic        rsp_blank
);
   import ldcp_pkg::*;

   // Nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response stays offered
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Fullness is a remainder of the frame capacity
   a_fullness: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_fullness) < FRAME_CAPACITY || FRAME_CAPACITY > 2047))
      else $error("fullness out of range");

   // Blank is only carried by points
   a_blank_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blank |-> rsp_kind == KIND_POINT)
      else $error("blank flag on a non-point response");

endmodule

bind laser_dac_command_parser_top ldcp_checker #(.FRAME_CAPACITY(FRAME_CAPACITY)) u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_kind     (rsp_bus.kind),
   .rsp_fullness (rsp_bus.fullness),
   .rsp_blank    (rsp_bus.blank)
);
